// ===== hw/rtl/smd_pkg.sv =====
// Shared types and constants of the scrolling matrix frame generator.
// Depends on nothing; imported by every module of the block.
package smd_pkg;

  // Display and store geometry
  localparam int DISP_HEIGHT     = 8;
  localparam int DISP_WIDTH      = 16;
  localparam int SCROLL_MAX_COLS = 256;

  // Derived widths
  localparam int PIX_W  = 8 * DISP_HEIGHT;
  localparam int ROW_W  = (DISP_HEIGHT > 1) ? $clog2(DISP_HEIGHT) : 1;
  localparam int FX_AW  = (DISP_WIDTH > 1) ? $clog2(DISP_WIDTH) : 1;
  localparam int SC_AW  = (SCROLL_MAX_COLS > 1) ? $clog2(SCROLL_MAX_COLS) : 1;
  localparam int X_W    = FX_AW;
  localparam int CNT_W  = $clog2(SCROLL_MAX_COLS + 1);
  localparam int OFS_W  = $clog2(DISP_WIDTH + SCROLL_MAX_COLS + 1) + 1;
  localparam int PER_W  = $clog2((DISP_WIDTH + SCROLL_MAX_COLS + 1) * 255 + 1);
  localparam int DVD_W  = 32;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int CFG_DW = 9;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_SPEED = 2'd2;

  // Display modes; the unused code renders blank
  localparam logic [1:0] MODE_BLANK  = 2'd0;
  localparam logic [1:0] MODE_FIXED  = 2'd1;
  localparam logic [1:0] MODE_SCROLL = 2'd2;

  typedef enum logic [1:0] {
    ACT_WR_FIXED  = 2'd0,
    ACT_WR_SCROLL = 2'd1,
    ACT_START     = 2'd2,
    ACT_RENDER    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_QUO,
    ST_COLS
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_FIXED,
    SRC_SCROLL
  } src_t;

  typedef struct packed {
    act_t        action;
    logic [2:0]  pixel_row;
    logic [7:0]  pixel_col;
    logic [7:0]  pixel_value;
    logic [31:0] frame_number;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  column_index;
    logic [63:0] column_pixels;
    logic        last_column;
  } out_res_t;

  // Pixel write into one of the stores
  typedef struct packed {
    logic             fx_en;
    logic             sc_en;
    logic [ROW_W-1:0] row;
    logic [FX_AW-1:0] fx_col;
    logic [SC_AW-1:0] sc_col;
    logic [7:0]       value;
  } store_wr_t;

  // Column read from the stores
  typedef struct packed {
    logic             fx_en;
    logic [FX_AW-1:0] fx_addr;
    logic             sc_en;
    logic [SC_AW-1:0] sc_addr;
  } store_rd_t;

endpackage

// ===== hw/rtl/scrolling_matrix_display_frame_gen_core.sv =====
// Top level of the scrolling matrix frame generator: sequencer, config, column walk.
// Depends on smd_pkg, smd_store and smd_div.
//
//   channel  ports                            handshake
//   -------  -------------------------------  ------------------------------
//   input    start, busy, in_req              taken when start && !busy
//   result   out_strobe, out_res              valid for one cycle, no stall
//   config   cfg_valid, cfg_ready, cfg_index,  written when valid && ready
//            cfg_data
//
// Pixel writes and scroll start complete when taken. A render makes two 32-step
// passes of the bit-serial divider (period modulo, then speed quotient), then
// one column read of the store memory per cycle for 16 columns. Each result is
// registered from the registered store read; busy covers the read pipeline.
// Reset (synchronous) clears control and config; the stores hold no reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
module scrolling_matrix_display_frame_gen_core
  import smd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_req,
  output logic              out_strobe,
  output out_res_t          out_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  state_t           state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [8:0]       cols_r;
  logic [7:0]       speed_r;
  logic [31:0]      start_frame_r;
  logic [31:0]      last_frame_r;
  logic signed [OFS_W-1:0] offset_r;
  logic [X_W-1:0]   x_r;
  logic             s1_vld_r;
  logic [X_W-1:0]   s1_x_r;
  src_t             s1_src_r;
  logic             out_strobe_r;
  out_res_t         out_res_r;

  logic             accept;
  logic             x_last;
  logic [CNT_W-1:0] cols_eff;
  logic [7:0]       speed_eff;
  logic [PER_W-1:0] period_c;
  logic [OFS_W:0]   col_c;
  logic             in_rng;
  src_t             src_c;
  store_wr_t        wr;
  store_rd_t        rd;
  logic [PIX_W-1:0] fx_q, sc_q;
  logic             div_go;
  logic [DVD_W-1:0] div_dividend;
  logic [PER_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [PER_W-1:0] div_rem;

  assign busy      = (state_r != ST_IDLE) || s1_vld_r;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign x_last    = (x_r == X_W'(DISP_WIDTH - 1));

  // Effective scroll settings and window period
  always_comb begin
    cols_eff  = (32'(cols_r) > SCROLL_MAX_COLS) ? CNT_W'(SCROLL_MAX_COLS) : CNT_W'(cols_r);
    speed_eff = (speed_r == 8'd0) ? 8'd1 : speed_r;
    period_c  = PER_W'((32'(DISP_WIDTH) + 32'(cols_eff) + 32'd1) * 32'(speed_eff));
  end

  // Store column for the current display column, and its range check
  always_comb begin
    col_c  = {offset_r[OFS_W-1], offset_r} + (OFS_W+1)'(x_r);
    in_rng = !col_c[OFS_W] && (col_c < (OFS_W+1)'(cols_eff));
  end

  // Pixel writes go straight to the stores; only taken while idle, so no
  // write can meet a render's column reads.
  always_comb begin
    wr.fx_en  = accept && (in_req.action == ACT_WR_FIXED) &&
                (32'(in_req.pixel_row) < DISP_HEIGHT) &&
                (32'(in_req.pixel_col) < DISP_WIDTH);
    wr.sc_en  = accept && (in_req.action == ACT_WR_SCROLL) &&
                (32'(in_req.pixel_row) < DISP_HEIGHT) &&
                (32'(in_req.pixel_col) < SCROLL_MAX_COLS);
    wr.row    = ROW_W'(in_req.pixel_row);
    wr.fx_col = FX_AW'(in_req.pixel_col);
    wr.sc_col = SC_AW'(in_req.pixel_col);
    wr.value  = in_req.pixel_value;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && (in_req.action == ACT_RENDER)) state_nxt = ST_MOD;
      ST_MOD:  if (div_done) state_nxt = ST_QUO;
      ST_QUO:  if (div_done) state_nxt = ST_COLS;
      ST_COLS: if (x_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider launches and column reads
  always_comb begin
    div_go       = 1'b0;
    div_dividend = in_req.frame_number - start_frame_r;
    div_divisor  = period_c;
    rd.fx_en     = 1'b0;
    rd.fx_addr   = FX_AW'(x_r);
    rd.sc_en     = 1'b0;
    rd.sc_addr   = SC_AW'(col_c);
    src_c        = SRC_ZERO;
    unique case (state_r)
      ST_IDLE: begin
        div_go = accept && (in_req.action == ACT_RENDER);
      end
      ST_MOD: begin
        div_go       = div_done;
        div_dividend = DVD_W'(div_rem);
        div_divisor  = PER_W'(speed_eff);
      end
      ST_QUO: begin
      end
      ST_COLS: begin
        if (mode_r == MODE_FIXED) begin
          rd.fx_en = 1'b1;
          src_c    = SRC_FIXED;
        end else if ((mode_r == MODE_SCROLL) && in_rng) begin
          rd.sc_en = 1'b1;
          src_c    = SRC_SCROLL;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_BLANK;
      cols_r        <= '0;
      speed_r       <= 8'd1;
      start_frame_r <= '0;
      last_frame_r  <= '0;
      x_r           <= '0;
      s1_vld_r      <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE:  mode_r  <= cfg_data[1:0];
          CFG_COLS:  cols_r  <= cfg_data[8:0];
          CFG_SPEED: speed_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (accept && (in_req.action == ACT_START)) begin
        start_frame_r <= last_frame_r;
      end
      if (accept && (in_req.action == ACT_RENDER)) begin
        last_frame_r <= in_req.frame_number;
      end
      if (state_r == ST_COLS) begin
        x_r <= x_last ? '0 : x_r + 1'b1;
      end
      s1_vld_r     <= (state_r == ST_COLS);
      out_strobe_r <= s1_vld_r;
    end
  end

  // Window offset, column pipeline and result payload
  always_ff @(posedge clk) begin
    if ((state_r == ST_QUO) && div_done) begin
      offset_r <= OFS_W'(div_quo) - OFS_W'(DISP_WIDTH);
    end
    s1_x_r   <= x_r;
    s1_src_r <= src_c;
    if (s1_vld_r) begin
      out_res_r.column_index <= 4'(s1_x_r);
      out_res_r.last_column  <= (s1_x_r == X_W'(DISP_WIDTH - 1));
      unique case (s1_src_r)
        SRC_FIXED:  out_res_r.column_pixels <= 64'(fx_q);
        SRC_SCROLL: out_res_r.column_pixels <= 64'(sc_q);
        default:    out_res_r.column_pixels <= '0;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  smd_store u_store (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .fx_q (fx_q),
    .sc_q (sc_q)
  );

  smd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

`ifndef SYNTHESIS
  // Columns of one frame come out back to back and in order
  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last_column |=>
      out_strobe && (out_res.column_index == $past(out_res.column_index) + 4'd1))
    else $error("column sequence broken");

  // Nothing follows the last column of a frame in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.last_column |=> !out_strobe)
    else $error("result after last column");

  // Divider results only arrive while the sequencer waits for them
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MOD || state_r == ST_QUO))
    else $error("divider done outside its wait states");
`endif

endmodule

// ===== hw/rtl/smd_store.sv =====
// Pixel stores: fixed frame and scroll content, one word per column.
// Depends on smd_pkg. Byte-wide writes, registered reads.
module smd_store
  import smd_pkg::*;
(
  input  logic             clk,
  input  store_wr_t        wr,
  input  store_rd_t        rd,
  output logic [PIX_W-1:0] fx_q,
  output logic [PIX_W-1:0] sc_q
);

  logic [PIX_W-1:0] fx_mem [DISP_WIDTH];
  logic [PIX_W-1:0] sc_mem [SCROLL_MAX_COLS];

  // Fixed store: byte lane per row
  always_ff @(posedge clk) begin
    if (wr.fx_en) begin
      fx_mem[wr.fx_col][8*wr.row +: 8] <= wr.value;
    end
    if (rd.fx_en) begin
      fx_q <= fx_mem[rd.fx_addr];
    end
  end

  // Scroll store
  always_ff @(posedge clk) begin
    if (wr.sc_en) begin
      sc_mem[wr.sc_col][8*wr.row +: 8] <= wr.value;
    end
    if (rd.sc_en) begin
      sc_q <= sc_mem[rd.sc_addr];
    end
  end

endmodule

// ===== hw/rtl/smd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the scroll window math.
// Depends on smd_pkg. Divisor must be nonzero.
module smd_div
  import smd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [PER_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [PER_W-1:0] remainder
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  quo_r;
  logic [PER_W-1:0]  rem_r;
  logic [PER_W-1:0]  dvs_r;
  logic [PER_W:0]    rem_sh;
  logic              ge;
  logic [PER_W-1:0]  rem_nxt;

  // One shift-and-subtract step
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? PER_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[PER_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
